>>> sv/sph_density_pressure_sum_defines.svh
// Assertion macros shared by the density/pressure summation block.
`ifndef SPH_DENSITY_PRESSURE_SUM_DEFINES_SVH
`define SPH_DENSITY_PRESSURE_SUM_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define SPH_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define SPH_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/sph_pkg.sv
// Shared types and constants of the density/pressure summation block.
package sph_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int ROOT_STEPS    = 32;
   localparam int CSR_IDX_W     = 3;

   localparam logic [31:0] KERNEL_SCALE_RST = 32'd7450;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INV_H      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KSCALE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REST       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_REST   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STIFFNESS  = 3'd4;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQX,
      OP_SQY,
      OP_ROOT_STEP,
      OP_MLO,
      OP_MHI,
      OP_MFIN,
      OP_POST,
      OP_DENS,
      OP_EMIT
   } op_type;

   // Fixed-point multiply jobs, in issue order
   typedef enum logic [3:0] {
      JOB_DIST,
      JOB_T2SQ,
      JOB_T2CU,
      JOB_T1SQ,
      JOB_T1CU,
      JOB_KERN,
      JOB_CONTRIB,
      JOB_RATIO,
      JOB_PRES
   } job_type;

   typedef struct packed {
      op_type  op;
      job_type job;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic out_busy;
   } status_type;

endpackage

>>> sv/sph_ctrl.sv
// Sequencer for the density/pressure summation: issues datapath commands per item.
`include "sph_density_pressure_sum_defines.svh"

module sph_ctrl
   import sph_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int CNT_W = $clog2(ROOT_STEPS);
   localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SQX, S_SQY, S_ROOT, S_MLO, S_MHI, S_MFIN, S_POST, S_DENS, S_EMIT
   } state_type;

   state_type         state_ff, state_in;
   job_type           job_ff, job_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Jobs whose result needs a follow-up step
   function automatic logic has_post(input job_type j);
      has_post = (j == JOB_DIST) || (j == JOB_T2CU) || (j == JOB_T1CU) ||
                 (j == JOB_CONTRIB) || (j == JOB_RATIO);
   endfunction

   function automatic job_type next_job(input job_type j);
      unique case (j)
         JOB_DIST:    next_job = JOB_T2SQ;
         JOB_T2SQ:    next_job = JOB_T2CU;
         JOB_T2CU:    next_job = JOB_T1SQ;
         JOB_T1SQ:    next_job = JOB_T1CU;
         JOB_T1CU:    next_job = JOB_KERN;
         JOB_KERN:    next_job = JOB_CONTRIB;
         JOB_RATIO:   next_job = JOB_PRES;
         default:     next_job = JOB_DIST;
      endcase
   endfunction

   // Where to go once a job is fully done
   function automatic state_type after_job(input job_type j, input logic last);
      priority if (j == JOB_CONTRIB) begin
         after_job = last ? S_DENS : S_IDLE;
      end else if (j == JOB_PRES) begin
         after_job = S_EMIT;
      end else begin
         after_job = S_MLO;
      end
   endfunction

   assign req_stall = (state_ff != S_IDLE);

   // Next state and command
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      cnt_in   = cnt_ff;
      cmd.op   = OP_NONE;
      cmd.job  = job_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            cmd.op   = OP_SQX;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.op   = OP_SQY;
            cnt_in   = '0;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            cmd.op = OP_ROOT_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ROOT_LAST) begin
               job_in   = JOB_DIST;
               state_in = S_MLO;
            end
         end
         S_MLO: begin
            cmd.op   = OP_MLO;
            state_in = S_MHI;
         end
         S_MHI: begin
            cmd.op   = OP_MHI;
            state_in = S_MFIN;
         end
         S_MFIN: begin
            cmd.op = OP_MFIN;
            if (has_post(job_ff)) begin
               state_in = S_POST;
            end else begin
               job_in   = next_job(job_ff);
               state_in = after_job(job_ff, status.last);
            end
         end
         S_POST: begin
            cmd.op   = OP_POST;
            job_in   = next_job(job_ff);
            state_in = after_job(job_ff, status.last);
         end
         S_DENS: begin
            cmd.op   = OP_DENS;
            job_in   = JOB_RATIO;
            state_in = S_MLO;
         end
         S_EMIT: begin
            if (!status.out_busy) begin
               cmd.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         job_ff   <= JOB_DIST;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
         cnt_ff   <= cnt_in;
      end
   end

   `SPH_ASSERT(a_emit_free, cmd.op == OP_EMIT, !status.out_busy, "emit over a stalled result")
   `SPH_ASSERT_NEXT(a_load_seq, cmd.op == OP_LOAD, state_ff == S_SQX, "load not followed by squares")
   `SPH_ASSERT_NEXT(a_root_exit, (state_ff == S_ROOT) && (cnt_ff == ROOT_LAST),
      (state_ff == S_MLO) && (job_ff == JOB_DIST), "root loop did not hand over to distance")

endmodule

>>> sv/sph_datapath.sv
// Datapath: config registers, shared multiplier, root unit, accumulator, result register.
`include "sph_density_pressure_sum_defines.svh"

module sph_datapath
   import sph_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic signed [31:0]   req_center_x,
   input  logic signed [31:0]   req_center_y,
   input  logic signed [31:0]   req_neighbor_x,
   input  logic signed [31:0]   req_neighbor_y,
   input  logic [31:0]          req_neighbor_mass,
   input  logic                 req_last_neighbor,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data,
   input  cmd_type              cmd,
   output status_type           status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_density,
   output logic [31:0]          rsp_pressure
);

   localparam logic [47:0] ONE_Q    = 48'd1 << FRAC_BITS;
   localparam logic [47:0] TWO_Q    = 48'd2 << FRAC_BITS;
   localparam logic [47:0] CAP_48   = {48{1'b1}};
   localparam logic [47:0] CAP_ACC  = {8'd0, {40{1'b1}}};
   localparam logic [47:0] CAP_32   = {16'd0, {32{1'b1}}};
   localparam logic [31:0] ONE_RST  = 32'd1 << FRAC_BITS;

   // Configuration
   logic [31:0] inv_h_ff, kscale_ff, rest_ff, inv_rest_ff, stiff_ff;

   // Item state
   logic [32:0] ax_ff, ay_ff;
   logic        shift_ff;
   logic [31:0] mass_ff;
   logic        last_ff;
   logic [63:0] sq_ff, rad_ff;
   logic [34:0] rem_ff;
   logic [31:0] root_ff;
   logic [63:0] plo_ff, phi_ff;
   logic [47:0] mres_ff;
   logic [31:0] t1_ff, t2_ff, inner_ff;
   logic [47:0] c2_ff, excess_ff;
   logic [31:0] dens_ff;

   // Run state
   logic [39:0] acc_ff;
   logic [1:0]  tally_ff;

   // Result register
   logic        rsp_valid_ff;
   logic [31:0] rsp_density_ff, rsp_pressure_ff;

   // Abs coordinate differences
   logic signed [32:0] dx, dy;
   logic [32:0]        ax_in, ay_in;
   always_comb begin
      dx    = 33'(req_center_x) - 33'(req_neighbor_x);
      dy    = 33'(req_center_y) - 33'(req_neighbor_y);
      ax_in = dx[32] ? 33'(-dx) : 33'(dx);
      ay_in = dy[32] ? 33'(-dy) : 33'(dy);
   end

   logic [31:0] hx, hy;
   logic [32:0] root_dist;
   assign hx        = shift_ff ? ax_ff[32:1] : ax_ff[31:0];
   assign hy        = shift_ff ? ay_ff[32:1] : ay_ff[31:0];
   assign root_dist = shift_ff ? {root_ff, 1'b0} : {1'b0, root_ff};

   // Multiplier operand select
   logic [31:0] mul_a;
   logic [47:0] mul_b;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      priority if (cmd.op == OP_SQX) begin
         mul_a = hx;
         mul_b = {16'd0, hx};
      end else if (cmd.op == OP_SQY) begin
         mul_a = hy;
         mul_b = {16'd0, hy};
      end else begin
         unique case (cmd.job)
            JOB_DIST:    begin mul_a = inv_h_ff;       mul_b = {15'd0, root_dist}; end
            JOB_T2SQ:    begin mul_a = t2_ff;          mul_b = {16'd0, t2_ff};    end
            JOB_T2CU:    begin mul_a = mres_ff[31:0];  mul_b = {16'd0, t2_ff};    end
            JOB_T1SQ:    begin mul_a = t1_ff;          mul_b = {16'd0, t1_ff};    end
            JOB_T1CU:    begin mul_a = mres_ff[31:0];  mul_b = {16'd0, t1_ff};    end
            JOB_KERN:    begin mul_a = kscale_ff;      mul_b = {16'd0, inner_ff}; end
            JOB_CONTRIB: begin mul_a = mass_ff;        mul_b = mres_ff;           end
            JOB_RATIO:   begin mul_a = dens_ff;        mul_b = {16'd0, inv_rest_ff}; end
            JOB_PRES:    begin mul_a = stiff_ff;       mul_b = excess_ff;         end
            default:     begin mul_a = '0;             mul_b = '0;                end
         endcase
      end
   end

   // One shared 32x32 multiplier; high half of b uses the upper 16 bits
   logic [63:0] prod;
   assign prod = mul_a * ((cmd.op == OP_MHI) ? {16'd0, mul_b[47:32]} : mul_b[31:0]);

   // Recombine partial products, scale and clamp
   logic [47:0] cap;
   logic [79:0] full, scaled;
   logic [47:0] mres_in;
   always_comb begin
      unique case (cmd.job)
         JOB_DIST:    cap = TWO_Q;
         JOB_CONTRIB: cap = CAP_ACC;
         JOB_PRES:    cap = CAP_32;
         default:     cap = CAP_48;
      endcase
      full    = {16'd0, plo_ff} + {phi_ff[47:0], 32'd0};
      scaled  = full >> FRAC_BITS;
      mres_in = (scaled > {32'd0, cap}) ? cap : scaled[47:0];
   end

   // Root step: two radicand bits per cycle
   logic [34:0] rem_sh, trial;
   assign rem_sh = {rem_ff[32:0], rad_ff[63:62]};
   assign trial  = {1'b0, root_ff, 2'b01};

   // Follow-up arithmetic
   logic [49:0] c1x4;
   logic [40:0] acc_sum;
   assign c1x4    = {mres_ff, 2'b00};
   assign acc_sum = {1'b0, acc_ff} + {1'b0, mres_ff[39:0]};

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_h_ff    <= ONE_RST;
         kscale_ff   <= KERNEL_SCALE_RST;
         rest_ff     <= ONE_RST;
         inv_rest_ff <= ONE_RST;
         stiff_ff    <= ONE_RST;
      end else if (csr_valid) begin
         priority case (csr_index)
            CSR_INV_H:     inv_h_ff    <= csr_data;
            CSR_KSCALE:    kscale_ff   <= csr_data;
            CSR_REST:      rest_ff     <= csr_data;
            CSR_INV_REST:  inv_rest_ff <= csr_data;
            CSR_STIFFNESS: stiff_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            ax_ff    <= ax_in;
            ay_ff    <= ay_in;
            shift_ff <= ax_in[32] | ax_in[31] | ay_in[32] | ay_in[31];
            mass_ff  <= req_neighbor_mass;
            last_ff  <= req_last_neighbor;
         end
         OP_SQX: sq_ff <= prod;
         OP_SQY: begin
            rad_ff  <= sq_ff + prod;
            rem_ff  <= '0;
            root_ff <= '0;
         end
         OP_ROOT_STEP: begin
            rad_ff <= {rad_ff[61:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[30:0], 1'b0};
            end
         end
         OP_MLO:  plo_ff  <= prod;
         OP_MHI:  phi_ff  <= prod;
         OP_MFIN: mres_ff <= mres_in;
         OP_POST: begin
            unique case (cmd.job)
               JOB_DIST: begin
                  t1_ff <= (mres_ff < ONE_Q) ? 32'(ONE_Q - mres_ff) : '0;
                  t2_ff <= (mres_ff < TWO_Q) ? 32'(TWO_Q - mres_ff) : '0;
               end
               JOB_T2CU: c2_ff <= mres_ff;
               JOB_T1CU: inner_ff <= ({2'b00, c2_ff} > c1x4) ?
                                     32'({2'b00, c2_ff} - c1x4) : '0;
               JOB_RATIO: excess_ff <= (mres_ff > ONE_Q) ? (mres_ff - ONE_Q) : '0;
               default: ;
            endcase
         end
         OP_DENS: dens_ff <= (tally_ff == 2'd1) ? rest_ff :
                             ((acc_ff[39:32] != 8'd0) ? {32{1'b1}} : acc_ff[31:0]);
         default: ;
      endcase
   end

   // Run accumulator and neighbor tally
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         tally_ff <= '0;
      end else if (cmd.op == OP_EMIT) begin
         acc_ff   <= '0;
         tally_ff <= '0;
      end else if ((cmd.op == OP_POST) && (cmd.job == JOB_CONTRIB)) begin
         acc_ff   <= acc_sum[40] ? {40{1'b1}} : acc_sum[39:0];
         tally_ff <= (tally_ff == 2'd2) ? 2'd2 : tally_ff + 2'd1;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         rsp_density_ff  <= dens_ff;
         rsp_pressure_ff <= mres_ff[31:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_density     = rsp_density_ff;
   assign rsp_pressure    = rsp_pressure_ff;
   assign status.last     = last_ff;
   assign status.out_busy = rsp_valid_ff & rsp_stall;

   `SPH_ASSERT(a_tally_range, 1'b1, tally_ff != 2'd3, "neighbor tally out of range")
   `SPH_ASSERT_NEXT(a_emit_clears, cmd.op == OP_EMIT,
      (acc_ff == '0) && (tally_ff == '0) && rsp_valid_ff, "emit did not close the run")
   `SPH_ASSERT_NEXT(a_lone_density, (cmd.op == OP_DENS) && (tally_ff == 2'd1),
      dens_ff == $past(rest_ff), "lone particle did not take rest density")

endmodule

>>> sv/sph_density_pressure_sum.sv
// Each neighbor item runs setup (load, x square, y square), 32 root steps, 7 multiplies
// (low, high and finish steps each) and 4 follow-up steps; a last item adds density and pressure.
// Throughput: one item at a time, set by the two-bits-per-step root and the single shared
// 32x32 multiplier. A finished result waits in its own register while the next run starts.
// Reset (synchronous, active high) restores register defaults and clears the run state.
// Top level of the SPH cubic-spline density and pressure summation block.
module sph_density_pressure_sum
   import sph_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [31:0]   req_center_x,
   input  logic signed [31:0]   req_center_y,
   input  logic signed [31:0]   req_neighbor_x,
   input  logic signed [31:0]   req_neighbor_y,
   input  logic [31:0]          req_neighbor_mass,
   input  logic                 req_last_neighbor,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_density,
   output logic [31:0]          rsp_pressure,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   sph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sph_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_neighbor_x    (req_neighbor_x),
      .req_neighbor_y    (req_neighbor_y),
      .req_neighbor_mass (req_neighbor_mass),
      .req_last_neighbor (req_last_neighbor),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_density       (rsp_density),
      .rsp_pressure      (rsp_pressure)
   );

endmodule
